>>> design/edfp_pkg.sv
// edfp_pkg: shared types and frame constants for the escape detector / frame packer
// no dependencies; imported by escape_detect_frame_packer, edfp_result_checker and tb_escape_detect_frame_packer

package edfp_pkg;

   // frame layout
   localparam int FRAME_BYTES  = 127;
   localparam int HEADER_BYTES = 12;
   localparam int CRC_BYTES    = 2;

   localparam logic [6:0] HEADER_POS  = 7'(HEADER_BYTES);
   localparam logic [6:0] CRC_LEN     = 7'(CRC_BYTES);
   localparam logic [7:0] SEND_LIMIT  = 8'(FRAME_BYTES - CRC_BYTES);
   localparam logic [7:0] PLUS_CHAR   = 8'h2B;
   localparam logic [1:0] PLUS_ESCAPE = 2'd3;

   // reset values of the csr registers
   localparam logic [7:0] GUARD_TICKS_RST = 8'd255;
   localparam logic [6:0] FLUSH_TICKS_RST = 7'd100;

   // csr register indexes
   localparam logic [1:0] CSR_GUARD_TICKS = 2'd0;
   localparam logic [1:0] CSR_FLUSH_TICKS = 2'd1;

   typedef enum logic [1:0] {
      ACT_BYTE = 2'd0,
      ACT_POLL = 2'd1,
      ACT_TICK = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SEND   = 2'd1,
      KIND_CONFIG = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_DATA   = 2'd0,
      MODE_GUARD  = 2'd1,
      MODE_PLUS   = 2'd2,
      MODE_CONFIG = 2'd3
   } mode_type;

endpackage

>>> design/escape_detect_frame_packer.sv
// escape_detect_frame_packer: escape guard-time detector and radio frame packer
// depends on edfp_pkg
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_action, req_data_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_kind, rsp_position, rsp_data,
//           |           |                     | rsp_sequence_res, rsp_mode, rsp_last
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// A transaction on req is evaluated in the cycle it is accepted; the step's
// result list is held in a result descriptor register and leaves one result per cycle.
// Each input yields its result items in turn; the next req transaction is
// accepted in the same cycle the step-done result is taken, so single-result steps
// run back to back. Synchronous active-high reset; csr_ready is always high.
// rsp_stall holds the current result and, on the final result, stalls req as well.

module escape_detect_frame_packer
   import edfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [6:0] rsp_position,
   output logic [7:0] rsp_data,
   output logic [7:0] rsp_sequence_res,
   output logic [1:0] rsp_mode,
   output logic       rsp_last,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // configuration registers
   logic [7:0] guard_ticks_ff;
   logic [6:0] flush_ticks_ff;

   // detector and packer state
   mode_type   mode_ff, mode_in;
   logic [7:0] guard_ff, guard_in;
   logic [6:0] flush_ff, flush_in;
   logic [1:0] plus_ff, plus_in;
   logic [6:0] fill_ff, fill_in;
   logic [7:0] seq_ff, seq_in;

   // result descriptor
   logic       busy_ff;
   logic       cfg_pend_ff, send_pend_ff, byte_pend_ff;
   logic [1:0] plus_left_ff;
   logic [6:0] wpos_ff;
   mode_type   rmode_ff;
   logic [6:0] send_pos_ff, send_pos_in;
   logic [7:0] byte_ff;

   // step evaluation
   logic       have, is_plus, step_act;
   logic       cfg_hit, send_hit, byte_wr;
   logic [6:0] fill_a, fill_b;
   logic [7:0] fill_sum;
   logic [1:0] nplus;

   // handshake
   logic       accept, take, done_take;
   kind_type   kind_sel;

   assign have     = (req_action == ACT_BYTE);
   assign is_plus  = have && (req_data_byte == PLUS_CHAR);
   assign step_act = (req_action == ACT_BYTE) || (req_action == ACT_POLL);

   // next escape mode
   always_comb begin
      mode_in = mode_ff;
      if (step_act) begin
         case (mode_ff)
            MODE_DATA: begin
               if (!have) mode_in = MODE_GUARD;
            end
            MODE_GUARD: begin
               if (have) mode_in = MODE_DATA;
               else if (guard_ff == 8'd0)
                  mode_in = (plus_ff == PLUS_ESCAPE) ? MODE_CONFIG : MODE_PLUS;
            end
            MODE_PLUS: begin
               if (is_plus) begin
                  if (plus_ff == 2'(PLUS_ESCAPE - 2'd1)) mode_in = MODE_GUARD;
               end else if (have) begin
                  mode_in = MODE_DATA;
               end
            end
            MODE_CONFIG: mode_in = MODE_DATA;
            default:     mode_in = MODE_DATA;
         endcase
      end
   end

   // counters, send decision and write plan for one step
   always_comb begin
      guard_in    = guard_ff;
      flush_in    = flush_ff;
      plus_in     = plus_ff;
      seq_in      = seq_ff;
      fill_in     = fill_ff;
      fill_a      = fill_ff;
      fill_b      = fill_ff;
      fill_sum    = 8'd0;
      cfg_hit     = 1'b0;
      send_hit    = 1'b0;
      send_pos_in = 7'd0;
      nplus       = 2'd0;
      byte_wr     = 1'b0;
      if (req_action == ACT_TICK) begin
         if (guard_ff != 8'd0) guard_in = guard_ff - 8'd1;
         if (flush_ff != 7'd0) flush_in = flush_ff - 7'd1;
      end else if (step_act) begin
         case (mode_ff)
            MODE_DATA: begin
               if (!have) guard_in = guard_ticks_ff;
            end
            MODE_GUARD: begin
               if (have) guard_in = 8'd0;
               else if (guard_ff == 8'd0) plus_in = 2'd0;
            end
            MODE_PLUS: begin
               if (is_plus) begin
                  plus_in = plus_ff + 2'd1;
                  // third plus restarts the trailing guard time
                  if (plus_ff == 2'(PLUS_ESCAPE - 2'd1)) guard_in = guard_ticks_ff;
               end
            end
            MODE_CONFIG: begin
               cfg_hit = 1'b1;
               fill_a  = HEADER_POS;
            end
            default: ;
         endcase
         fill_b = fill_a;
         // full frame or flush timeout
         if (mode_in != MODE_CONFIG) begin
            fill_sum = {1'b0, fill_a} + {6'd0, plus_in};
            if ((fill_sum >= SEND_LIMIT) || ((flush_ff == 7'd0) && (fill_a > HEADER_POS))) begin
               send_hit    = 1'b1;
               seq_in      = seq_ff + 8'd1;
               send_pos_in = fill_a + CRC_LEN;
               flush_in    = flush_ticks_ff;
               fill_b      = HEADER_POS;
            end
         end
         // held-back pluses then the byte itself
         if (mode_in == MODE_DATA) begin
            nplus   = plus_in;
            plus_in = 2'd0;
            byte_wr = have;
            fill_in = fill_b + {5'd0, nplus} + {6'd0, have};
         end else begin
            fill_in = fill_b;
         end
      end
   end

   // current result: configure, send, pluses, byte, then step done
   always_comb begin
      kind_sel         = KIND_DONE;
      rsp_position     = 7'd0;
      rsp_data         = 8'd0;
      rsp_sequence_res = 8'd0;
      rsp_last         = 1'b0;
      if (cfg_pend_ff) begin
         kind_sel = KIND_CONFIG;
      end else if (send_pend_ff) begin
         kind_sel         = KIND_SEND;
         rsp_position     = send_pos_ff;
         rsp_sequence_res = seq_ff;
      end else if (plus_left_ff != 2'd0) begin
         kind_sel     = KIND_WRITE;
         rsp_position = wpos_ff;
         rsp_data     = PLUS_CHAR;
      end else if (byte_pend_ff) begin
         kind_sel     = KIND_WRITE;
         rsp_position = wpos_ff;
         rsp_data     = byte_ff;
      end else begin
         rsp_last = 1'b1;
      end
   end

   assign rsp_kind  = kind_sel;
   assign rsp_mode  = rmode_ff;
   assign rsp_valid = busy_ff;
   assign csr_ready = 1'b1;

   assign take      = busy_ff && !rsp_stall;
   assign done_take = take && rsp_last;
   assign req_stall = busy_ff && !done_take;
   assign accept    = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ticks_ff <= GUARD_TICKS_RST;
         flush_ticks_ff <= FLUSH_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_GUARD_TICKS) guard_ticks_ff <= csr_wdata;
         if (csr_index == CSR_FLUSH_TICKS) flush_ticks_ff <= csr_wdata[6:0];
      end
   end

   // detector state, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DATA;
         guard_ff <= 8'd0;
         flush_ff <= 7'd0;
         plus_ff  <= 2'd0;
         fill_ff  <= HEADER_POS;
         seq_ff   <= 8'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         guard_ff <= guard_in;
         flush_ff <= flush_in;
         plus_ff  <= plus_in;
         fill_ff  <= fill_in;
         seq_ff   <= seq_in;
      end
   end

   // descriptor control: load on accept, retire one result per taken transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cfg_pend_ff  <= 1'b0;
         send_pend_ff <= 1'b0;
         plus_left_ff <= 2'd0;
         byte_pend_ff <= 1'b0;
         wpos_ff      <= HEADER_POS;
         rmode_ff     <= MODE_DATA;
      end else if (accept) begin
         busy_ff      <= 1'b1;
         cfg_pend_ff  <= cfg_hit;
         send_pend_ff <= send_hit;
         plus_left_ff <= nplus;
         byte_pend_ff <= byte_wr;
         wpos_ff      <= fill_b;
         rmode_ff     <= mode_in;
      end else if (take) begin
         if (cfg_pend_ff) begin
            cfg_pend_ff <= 1'b0;
         end else if (send_pend_ff) begin
            send_pend_ff <= 1'b0;
         end else if (plus_left_ff != 2'd0) begin
            plus_left_ff <= plus_left_ff - 2'd1;
            wpos_ff      <= wpos_ff + 7'd1;
         end else if (byte_pend_ff) begin
            byte_pend_ff <= 1'b0;
            wpos_ff      <= wpos_ff + 7'd1;
         end else begin
            busy_ff <= 1'b0;
         end
      end
   end

   // descriptor payload
   always_ff @(posedge clock) begin
      if (accept) begin
         send_pos_ff <= send_pos_in;
         byte_ff     <= req_data_byte;
      end
   end

`ifndef SYNTHESIS
   // an accepted transaction always has results waiting next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction left no result");

   // fill index stays inside the payload area
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff >= HEADER_POS) && ({1'b0, fill_ff} <= SEND_LIMIT))
      else $error("fill index out of frame");

   // held-back pluses exist only while the escape is being tracked
   assert property (@(posedge clock) disable iff (reset)
      (plus_ff != 2'd0) |-> ((mode_ff == MODE_GUARD) || (mode_ff == MODE_PLUS)))
      else $error("plus count outside escape tracking");
`endif

endmodule

>>> test/edfp_result_checker.sv
// edfp_result_checker: watches the req, rsp and csr channels of the escape detector / frame
// packer, predicts every result of each accepted step and compares them in order
// depends on edfp_pkg
`timescale 1ns / 100ps

module edfp_result_checker
   import edfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_kind,
   input  logic [6:0] rsp_position,
   input  logic [7:0] rsp_data,
   input  logic [7:0] rsp_sequence_res,
   input  logic [1:0] rsp_mode,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         outstanding
);

   typedef struct {
      kind_type   kind;
      logic [6:0] position;
      logic [7:0] data;
      logic [7:0] sequence_res;
      mode_type   mode;
      logic       last;
   } packer_result_type;

   // results predicted but not yet seen on rsp
   packer_result_type pending_results[$];

   // shadow of the csr registers
   logic [7:0] guard_ticks_cfg;
   logic [6:0] flush_ticks_cfg;

   // shadow of the detector and packer state
   mode_type   esc_mode;
   logic [7:0] guard_cnt;
   logic [6:0] flush_cnt;
   logic [1:0] plus_cnt;
   logic [6:0] fill_idx;
   logic [7:0] frame_seq;

   function automatic packer_result_type frame_event(kind_type kind, logic [6:0] position,
                                                     logic [7:0] data, logic [7:0] seq);
      packer_result_type r;
      r.kind         = kind;
      r.position     = position;
      r.data         = data;
      r.sequence_res = seq;
      r.mode         = MODE_DATA;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic int field_mismatch(string name, int expv, int actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
         return 1;
      end
      return 0;
   endfunction

   // one input step: update the shadow state and queue its results
   task automatic predict_packer_step(input logic [1:0] act, input logic [7:0] rx_byte);
      packer_result_type step_results[$];
      logic have;
      logic send;
      have = (act == ACT_BYTE);
      send = 1'b0;
      if (act == ACT_TICK) begin
         // counters run down and rest at zero
         if (guard_cnt != 0) guard_cnt = guard_cnt - 8'd1;
         if (flush_cnt != 0) flush_cnt = flush_cnt - 7'd1;
      end else if (act == ACT_BYTE || act == ACT_POLL) begin
         // escape detector
         case (esc_mode)
            MODE_DATA: begin
               if (!have) begin
                  guard_cnt = guard_ticks_cfg;
                  esc_mode  = MODE_GUARD;
               end
            end
            MODE_GUARD: begin
               if (have) begin
                  guard_cnt = '0;
                  esc_mode  = MODE_DATA;
               end else if (guard_cnt == 0) begin
                  esc_mode = (plus_cnt == PLUS_ESCAPE) ? MODE_CONFIG : MODE_PLUS;
                  plus_cnt = '0;
               end
            end
            MODE_PLUS: begin
               if (have && rx_byte == PLUS_CHAR) begin
                  plus_cnt = plus_cnt + 2'd1;
                  // third plus reloads the guard timer
                  if (plus_cnt == PLUS_ESCAPE) begin
                     guard_cnt = guard_ticks_cfg;
                     esc_mode  = MODE_GUARD;
                  end
               end else if (have) begin
                  esc_mode = MODE_DATA;
               end
            end
            default: begin
               // pending configure request goes out and the buffer restarts
               step_results.push_back(frame_event(KIND_CONFIG, '0, '0, '0));
               fill_idx = HEADER_POS;
               esc_mode = MODE_DATA;
            end
         endcase

         // frame send when full or when the flush timer has run out
         if (esc_mode != MODE_CONFIG) begin
            if (int'(fill_idx) + int'(plus_cnt) >= int'(SEND_LIMIT)) begin
               send = 1'b1;
            end else if (flush_cnt == 0 && fill_idx > HEADER_POS) begin
               send = 1'b1;
            end
            if (send) begin
               frame_seq = frame_seq + 8'd1;
               step_results.push_back(frame_event(KIND_SEND, fill_idx + CRC_LEN, '0, frame_seq));
               flush_cnt = flush_ticks_cfg;
               fill_idx  = HEADER_POS;
            end
         end

         // held-back pluses first, then the byte itself
         if (esc_mode == MODE_DATA) begin
            while (plus_cnt != 0) begin
               plus_cnt = plus_cnt - 2'd1;
               step_results.push_back(frame_event(KIND_WRITE, fill_idx, PLUS_CHAR, '0));
               fill_idx = fill_idx + 7'd1;
            end
            if (have) begin
               step_results.push_back(frame_event(KIND_WRITE, fill_idx, rx_byte, '0));
               fill_idx = fill_idx + 7'd1;
            end
         end
      end

      step_results.push_back(frame_event(KIND_DONE, '0, '0, '0));
      foreach (step_results[k]) begin
         step_results[k].mode = esc_mode;
         step_results[k].last = (k == step_results.size() - 1);
         pending_results.push_back(step_results[k]);
      end
   endtask

   // channel monitor
   always @(posedge clock) begin : monitor
      packer_result_type exp_r;
      int errs;
      if (reset) begin
         guard_ticks_cfg = GUARD_TICKS_RST;
         flush_ticks_cfg = FLUSH_TICKS_RST;
         esc_mode        = MODE_DATA;
         guard_cnt       = '0;
         flush_cnt       = '0;
         plus_cnt        = '0;
         fill_idx        = HEADER_POS;
         frame_seq       = '0;
         fail_count      = 0;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         // csr write transaction
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GUARD_TICKS) begin
               guard_ticks_cfg = csr_wdata;
            end else if (csr_index == CSR_FLUSH_TICKS) begin
               flush_ticks_cfg = csr_wdata[6:0];
            end
         end

         // input transaction
         if (req_valid && !req_stall) begin
            predict_packer_step(req_action, req_data_byte);
         end

         // result transaction
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: kind %0d position %0d data %0d", rsp_kind,
                      rsp_position, rsp_data);
               fail_count++;
            end else begin
               exp_r = pending_results.pop_front();
               errs  = field_mismatch("kind", exp_r.kind, rsp_kind)
                     + field_mismatch("position", exp_r.position, rsp_position)
                     + field_mismatch("data", exp_r.data, rsp_data)
                     + field_mismatch("sequence_res", exp_r.sequence_res, rsp_sequence_res)
                     + field_mismatch("mode", exp_r.mode, rsp_mode)
                     + field_mismatch("last", exp_r.last, rsp_last);
               if (errs != 0) fail_count++;
            end
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

>>> test/tb_escape_detect_frame_packer.sv
// tb_escape_detect_frame_packer: stimulus and verdict for the escape detector / frame packer
// drives serial bytes, polls, ticks and csr writes; checking lives in edfp_result_checker
// depends on edfp_pkg, escape_detect_frame_packer and edfp_result_checker
`timescale 1ns / 100ps

module tb_escape_detect_frame_packer;
   import edfp_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         HOLD_CYCLES = 80;
   localparam int         BURST_BYTES = 15;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } serial_item_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [1:0] req_action    = '0;
   logic [7:0] req_data_byte = '0;
   logic       rsp_stall     = 1'b0;
   logic       csr_valid     = 1'b0;
   logic [1:0] csr_index     = '0;
   logic [7:0] csr_wdata     = '0;

   logic       req_stall;
   logic       rsp_valid;
   logic [1:0] rsp_kind;
   logic [6:0] rsp_position;
   logic [7:0] rsp_data;
   logic [7:0] rsp_sequence_res;
   logic [1:0] rsp_mode;
   logic       rsp_last;
   logic       csr_ready;

   int fail_count;
   int outstanding;

   // idling percentages and receiver hold-off control
   int         tx_idle_pct   = 22;
   int         rx_idle_pct   = 73;
   logic       hold_on       = 1'b0;
   logic       hold_go       = 1'b0;
   int         items_sent    = 0;
   logic [7:0] guard_setting = GUARD_TICKS_RST;

   always #1 clock = ~clock;

   escape_detect_frame_packer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_data         (rsp_data),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_mode         (rsp_mode),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   edfp_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_data         (rsp_data),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_mode         (rsp_mode),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // receiver stall: random idling plus the long hold-off
   always @(posedge clock) begin
      rsp_stall <= hold_on || ($urandom_range(99) < rx_idle_pct);
   end

   // long receiver hold-off so the block fills up and stalls req
   initial begin : receiver_hold
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin : watchdog
      #1000000;
      $display("** escape_detect_frame_packer: FAILED **");
      $finish;
   end

   // one req transaction, with random sender gaps in front
   task automatic offer_item(input logic [1:0] act, input logic [7:0] rx_byte);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= rx_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // csr write transaction; the caller lowers csr_valid after the last one
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GUARD_TICKS) guard_setting = value;
   endtask

   // wait until every result is in, then load both registers
   task automatic drain_and_configure(input logic [7:0] guard, input logic [6:0] flush);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      write_csr(CSR_GUARD_TICKS, guard);
      write_csr(CSR_FLUSH_TICKS, {1'b0, flush});
      csr_valid <= 1'b0;
   endtask

   // guard silence, three pluses, guard silence, then the trigger;
   // a broken one ends early on a random byte
   task automatic run_escape(input bit broken);
      serial_item_type seq_items[$];
      int ticks;
      int cut;
      ticks = (guard_setting <= 6) ? int'(guard_setting) : int'($urandom_range(6));
      seq_items.push_back({ACT_POLL, 8'($urandom)});
      repeat (ticks) seq_items.push_back({ACT_TICK, 8'($urandom)});
      seq_items.push_back({ACT_POLL, 8'($urandom)});
      repeat (3) seq_items.push_back({ACT_BYTE, PLUS_CHAR});
      repeat (ticks) seq_items.push_back({ACT_TICK, 8'($urandom)});
      seq_items.push_back({ACT_POLL, 8'($urandom)});
      if ($urandom_range(1) == 0) seq_items.push_back({ACT_BYTE, 8'($urandom)});
      else seq_items.push_back({ACT_POLL, 8'($urandom)});
      if (broken) begin
         cut = $urandom_range(seq_items.size() - 2);
         seq_items[cut] = {ACT_BYTE, 8'($urandom)};
         while (seq_items.size() > cut + 1) void'(seq_items.pop_back());
      end
      foreach (seq_items[k]) offer_item(seq_items[k].action, seq_items[k].data_byte);
   endtask

   // random mix: mostly escape sequences, then data bursts and noise
   task automatic run_random(input int count);
      int stop;
      int pick;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            run_escape(1'b0);
         end else if (pick < 60) begin
            run_escape(1'b1);
         end else if (pick < 85) begin
            repeat ($urandom_range(8, 1)) begin
               offer_item(ACT_BYTE, ($urandom_range(3) == 0) ? PLUS_CHAR : 8'($urandom));
            end
         end else begin
            offer_item(2'($urandom_range(3)), 8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, unused action, full escape, broken escape
      drain_and_configure(8'd2, 7'd5);
      offer_item(ACT_BYTE, 8'h00);
      offer_item(ACT_BYTE, 8'hFF);
      offer_item(ACT_UNUSED, 8'h5A);
      offer_item(ACT_TICK, 8'hA5);
      offer_item(ACT_POLL, 8'h00);
      repeat (2) offer_item(ACT_TICK, 8'h00);
      offer_item(ACT_POLL, 8'hFF);
      repeat (3) offer_item(ACT_BYTE, PLUS_CHAR);
      // guard reloaded by the third plus, so this poll keeps waiting
      offer_item(ACT_POLL, 8'h00);
      repeat (2) offer_item(ACT_TICK, 8'h00);
      offer_item(ACT_POLL, 8'h00);
      // byte arriving with the configure request pending
      offer_item(ACT_BYTE, 8'h41);
      offer_item(ACT_POLL, 8'h00);
      offer_item(ACT_POLL, 8'h00);
      repeat (2) offer_item(ACT_TICK, 8'h00);
      offer_item(ACT_POLL, 8'h00);
      repeat (2) offer_item(ACT_BYTE, PLUS_CHAR);
      // two held-back pluses flushed ahead of this byte
      offer_item(ACT_BYTE, 8'h80);
      offer_item(ACT_BYTE, 8'h7F);

      // zero guard and zero flush
      drain_and_configure(8'd0, 7'd0);
      run_random(15);

      // sender idles more than receiver; a short data burst
      tx_idle_pct = 73;
      rx_idle_pct = 22;
      drain_and_configure(8'd3, 7'd127);
      repeat (BURST_BYTES) offer_item(ACT_BYTE, 8'($urandom));
      run_random(12);

      // no idling; maximum guard and the receiver hold-off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      drain_and_configure(8'd255, 7'd64);
      hold_go = 1'b1;
      run_random(12);

      drain_and_configure(8'd1, 7'd3);
      run_random(12);

      // drain and let the block settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("** escape_detect_frame_packer: PASSED **");
      end else begin
         $display("** escape_detect_frame_packer: FAILED **");
      end
      $finish;
   end

endmodule
